// ===== rtl/rmp_pkg.sv =====
// Shared types and codes for the running median store.
// No dependencies; used by the channel interfaces and running_median_pop.
package rmp_pkg;

  localparam int OP_W = 2;
  localparam int ST_W = 2;

  typedef logic [OP_W-1:0] op_t;
  typedef logic [ST_W-1:0] status_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_POP    = 2'd1;
  localparam op_t OP_CLEAR  = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

// ===== rtl/rmp_if.sv =====
// Valid/ready channel interfaces for command items and result items.
// Depends on rmp_pkg for the opcode and status types.
interface rmp_in_if #(
  parameter int VALUE_BITS = 31
);
  logic                   valid;
  logic                   ready;
  rmp_pkg::op_t           opcode;
  logic [VALUE_BITS-1:0]  value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface rmp_out_if #(
  parameter int VALUE_BITS = 31
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_BITS-1:0]  median;
  rmp_pkg::status_t       status;

  modport source (output valid, output median, output status, input ready);
  modport sink   (input valid, input median, input status, output ready);
endinterface

// ===== rtl/running_median_pop.sv =====
// Running median store: sorted memory with insert, median pop and clear.
// Depends on rmp_pkg and the channel interfaces in rmp_if.sv.
//
//   channel | dir | handshake          | payload
//   in_ch   | in  | valid / ready      | opcode, value
//   out_ch  | out | valid / ready      | median, status
//
// One item at a time; an insert walks the sorted memory with a single
// comparator. The memory has one write port and one registered read port.
// Insert moves each entry above the new value up one, read then write, and
// drops the value into the hole; pop reads the median, then moves each entry
// above it down one. Clear, errors and unknown opcodes go straight to the
// result. No clearing pass: the entry count alone marks valid entries.
// Reset is synchronous, active low.
// A stalled result sits in the output register; the next item is taken
// meanwhile and waits at its end until the register frees.
module running_median_pop #(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 31
) (
  input  logic      clk,
  input  logic      rst_n,
  rmp_in_if.sink    in_ch,
  rmp_out_if.source out_ch
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_POP_RD  = 3'd3;
  localparam logic [2:0] S_POP_CAP = 3'd4;
  localparam logic [2:0] S_SHF_RD  = 3'd5;
  localparam logic [2:0] S_SHF_WR  = 3'd6;
  localparam logic [2:0] S_FIN     = 3'd7;

  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       ptr_r, ptr_nxt;
  logic [VALUE_BITS-1:0]  val_r, val_nxt;
  logic [VALUE_BITS-1:0]  med_r, med_nxt;
  rmp_pkg::status_t       sts_r, sts_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0]  out_median_r, out_median_nxt;
  rmp_pkg::status_t       out_status_r, out_status_nxt;

  logic [VALUE_BITS-1:0]  mem [CAPACITY];
  logic [VALUE_BITS-1:0]  rd_data_r;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [VALUE_BITS-1:0]  mem_wdata;

  logic                   in_acc;
  logic                   out_load;
  logic [CNT_W-1:0]       ptr_inc;
  logic [CNT_W-1:0]       ptr_dec;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign out_load      = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);
  assign ptr_inc       = ptr_r + CNT_ONE;
  assign ptr_dec       = ptr_r - CNT_ONE;

  assign out_ch.valid  = out_valid_r;
  assign out_ch.median = out_median_r;
  assign out_ch.status = out_status_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    val_nxt   = val_r;
    med_nxt   = med_r;
    sts_nxt   = sts_r;
    rd_addr   = '0;
    mem_we    = 1'b0;
    mem_waddr = ptr_r[ADDR_W-1:0];
    mem_wdata = val_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          med_nxt   = '0;
          sts_nxt   = rmp_pkg::ST_OK;
          val_nxt   = in_ch.value;
          state_nxt = S_FIN;
          case (in_ch.opcode)
            rmp_pkg::OP_INSERT: begin
              if (cnt_r == CNT_FULL) begin
                sts_nxt = rmp_pkg::ST_FULL;
              end else begin
                ptr_nxt   = cnt_r;
                state_nxt = S_INS_RD;
              end
            end
            rmp_pkg::OP_POP: begin
              if (cnt_r == '0) begin
                sts_nxt = rmp_pkg::ST_EMPTY;
              end else begin
                ptr_nxt   = (cnt_r - CNT_ONE) >> 1;
                state_nxt = S_POP_RD;
              end
            end
            rmp_pkg::OP_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_INS_RD: begin
        // ptr_r is the hole; drop the value in once nothing lies below it
        if (ptr_r == '0) begin
          mem_we    = 1'b1;
          cnt_nxt   = cnt_r + CNT_ONE;
          state_nxt = S_FIN;
        end else begin
          rd_addr   = ptr_dec[ADDR_W-1:0];
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (rd_data_r > val_r) begin
          // move the larger entry up one and advance the hole down
          mem_wdata = rd_data_r;
          ptr_nxt   = ptr_dec;
          state_nxt = S_INS_RD;
        end else begin
          cnt_nxt   = cnt_r + CNT_ONE;
          state_nxt = S_FIN;
        end
      end
      S_POP_RD: begin
        rd_addr   = ptr_r[ADDR_W-1:0];
        state_nxt = S_POP_CAP;
      end
      S_POP_CAP: begin
        med_nxt   = rd_data_r;
        state_nxt = S_SHF_RD;
      end
      S_SHF_RD: begin
        if (ptr_inc >= cnt_r) begin
          cnt_nxt   = cnt_r - CNT_ONE;
          state_nxt = S_FIN;
        end else begin
          rd_addr   = ptr_inc[ADDR_W-1:0];
          state_nxt = S_SHF_WR;
        end
      end
      S_SHF_WR: begin
        // close the gap left by the median
        mem_we    = 1'b1;
        mem_wdata = rd_data_r;
        ptr_nxt   = ptr_inc;
        state_nxt = S_SHF_RD;
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_median_nxt = out_median_r;
    out_status_nxt = out_status_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_median_nxt = med_r;
      out_status_nxt = sts_r;
    end else if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    val_r        <= val_nxt;
    med_r        <= med_nxt;
    sts_r        <= sts_nxt;
    out_median_r <= out_median_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("entry count above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("block idle right after taking an item");

  a_hole_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_CMP) |-> (ptr_r != '0) && (ptr_r <= cnt_r) && (cnt_r < CNT_FULL))
    else $error("insert hole outside the stored range");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && sts_r == rmp_pkg::ST_FULL) |-> cnt_r == CNT_FULL)
    else $error("full status with room left");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHF_WR) |-> ptr_inc < cnt_r)
    else $error("pop shift reads beyond the stored entries");

endmodule
